// ===== hdl/atx_pkg.sv =====
// shared types, constants and saturation helper for the affine point transform
package atx_pkg;

	localparam int DEF_FRAC_BITS = 16;
	localparam int COORD_W       = 32;
	// widest signed sum of two products plus the shifted offset
	localparam int SUM_W         = 66;
	// signed determinant width
	localparam int DET_W         = 65;
	// magnitude width handed to the saturation helper
	localparam int MAG_W         = 128;
	localparam int QDEPTH        = 4;
	localparam int CFG_IDX_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHEAR_X  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHEAR_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;

	typedef enum logic {
		OP_FWD = 1'b0,
		OP_INV = 1'b1
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
	} atx_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] a;
		logic signed [COORD_W-1:0] c;
		logic signed [COORD_W-1:0] tx;
		logic signed [COORD_W-1:0] b;
		logic signed [COORD_W-1:0] d;
		logic signed [COORD_W-1:0] ty;
	} atx_mat_t;

	typedef struct packed {
		logic [COORD_W-1:0] rx;
		logic [COORD_W-1:0] ry;
		logic               sing;
		logic               ovf;
	} atx_res_t;

	typedef struct packed {
		logic               ovf;
		logic [COORD_W-1:0] val;
	} atx_sat_t;

	typedef struct packed {
		logic             negx;
		logic             negy;
		logic [SUM_W-1:0] magx;
		logic [SUM_W-1:0] magy;
		logic [DET_W-1:0] dv;
	} atx_div_req_t;

	typedef struct packed {
		logic div_busy;
		logic s3_issue;
	} atx_stat_t;

	// sign and magnitude to saturated two's complement
	function automatic atx_sat_t atx_saturate(logic neg, logic [MAG_W-1:0] mag);
		logic [MAG_W-1:0] lim;
		atx_sat_t r;
		lim = neg ? MAG_W'(33'h080000000) : MAG_W'(32'h7fffffff);
		if (mag > lim) begin
			r.ovf = 1'b1;
			r.val = neg ? 32'h80000000 : 32'h7fffffff;
		end else begin
			r.ovf = 1'b0;
			r.val = neg ? (32'd0 - mag[COORD_W-1:0]) : mag[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/atx_front.sv =====
// front end: accepts input beats, tags the operation and queues them
module atx_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              opcode,
	input  logic [31:0]       point_x,
	input  logic [31:0]       point_y,
	input  logic              pop,
	output atx_pkg::atx_item_t head,
	output logic              head_valid
);
	import atx_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);

	atx_item_t        buf_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             push;
	logic             do_pop;
	atx_item_t        item;

	// classify and pack the incoming beat
	always_comb begin
		item.op = op_t'(opcode);
		item.px = point_x;
		item.py = point_y;
	end

	assign in_ready   = cnt_q != (PTR_W+1)'(QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = buf_q[rd_ptr_q];
	assign push       = in_valid && in_ready;
	assign do_pop     = pop && head_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= item;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/atx_div.sv =====
// iterative restoring divider for both inverse axes, one quotient bit per cycle
module atx_div #(
	parameter int FRAC_BITS = atx_pkg::DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  atx_pkg::atx_div_req_t req,
	input  logic                 take,
	output logic                 busy,
	output logic                 done,
	output atx_pkg::atx_res_t    res
);
	import atx_pkg::*;

	localparam int NW = SUM_W + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0]    nx_q, ny_q;
	logic [NW-1:0]    qx_q, qy_q;
	logic [DET_W-1:0] rx_q, ry_q;
	logic [DET_W-1:0] dv_q;
	logic             negx_q, negy_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DET_W:0]   rrx, rry;
	logic             gex, gey;
	logic [DET_W:0]   subx, suby;
	logic             rndx, rndy;
	logic [NW:0]      qrx, qry;
	atx_sat_t         satx, saty;

	// one restoring step per axis
	always_comb begin
		rrx  = {rx_q, nx_q[NW-1]};
		rry  = {ry_q, ny_q[NW-1]};
		gex  = rrx >= {1'b0, dv_q};
		gey  = rry >= {1'b0, dv_q};
		subx = rrx - {1'b0, dv_q};
		suby = rry - {1'b0, dv_q};
	end

	// round half away from zero, then saturate
	always_comb begin
		rndx = {rx_q, 1'b0} >= {1'b0, dv_q};
		rndy = {ry_q, 1'b0} >= {1'b0, dv_q};
		qrx  = {1'b0, qx_q} + (NW+1)'(rndx);
		qry  = {1'b0, qy_q} + (NW+1)'(rndy);
		satx = atx_saturate(negx_q, MAG_W'(qrx));
		saty = atx_saturate(negy_q, MAG_W'(qry));
		res.rx   = satx.val;
		res.ry   = saty.val;
		res.sing = 1'b0;
		res.ovf  = satx.ovf || saty.ovf;
	end

	assign busy = run_q || done_q;
	assign done = done_q;

	// datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			nx_q   <= NW'(req.magx) << FRAC_BITS;
			ny_q   <= NW'(req.magy) << FRAC_BITS;
			qx_q   <= '0;
			qy_q   <= '0;
			rx_q   <= '0;
			ry_q   <= '0;
			dv_q   <= req.dv;
			negx_q <= req.negx;
			negy_q <= req.negy;
		end else if (run_q) begin
			nx_q <= nx_q << 1;
			ny_q <= ny_q << 1;
			qx_q <= {qx_q[NW-2:0], gex};
			qy_q <= {qy_q[NW-2:0], gey};
			rx_q <= gex ? subx[DET_W-1:0] : rrx[DET_W-1:0];
			ry_q <= gey ? suby[DET_W-1:0] : rry[DET_W-1:0];
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (start) begin
				cnt_q <= CW'(NW);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (take) begin
				done_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/atx_back.sv =====
// back end: operand prep, shared multipliers, sums, divider hand-off and output register
module atx_back #(
	parameter int FRAC_BITS = atx_pkg::DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  atx_pkg::atx_mat_t  mat,
	input  atx_pkg::atx_item_t head,
	input  logic               head_valid,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output atx_pkg::atx_res_t  res,
	output atx_pkg::atx_stat_t stat
);
	import atx_pkg::*;

	// stage 1: operands
	logic                      v_s1;
	op_t                       op_s1;
	logic signed [32:0]        px_s1, py_s1, dx_s1, dy_s1;
	// stage 2: products
	logic                      v_s2;
	op_t                       op_s2;
	logic signed [SUM_W-1:0]   p0_s2, p1_s2, p2_s2, p3_s2;
	logic signed [63:0]        ad_s2, bc_s2;
	// stage 3: sums
	logic                      v_s3;
	op_t                       op_s3;
	logic signed [SUM_W-1:0]   sx_s3, sy_s3;
	logic signed [DET_W-1:0]   det_s3;
	// output register
	logic                      out_v_q;
	atx_res_t                  out_q;

	logic en1, en2, en3, s3_go, needs_out, out_can, inv3, sing3;
	logic signed [32:0]        ma0, mb0, ma1, mb1, ma2, mb2, ma3, mb3;
	logic signed [SUM_W-1:0]   pr0, pr1, pr2, pr3;
	logic signed [63:0]        prad, prbc;
	logic signed [SUM_W-1:0]   txs, tys, sumx, sumy;
	logic [SUM_W-1:0]          magx, magy;
	logic [SUM_W:0]            half, rx_rnd, ry_rnd;
	atx_sat_t                  fx, fy;
	atx_res_t                  s3_res;
	atx_div_req_t              dreq;
	logic                      div_busy, div_done, div_take;
	atx_res_t                  div_res;

	// stall chain
	assign out_can   = !out_v_q || out_ready;
	assign inv3      = op_s3 == OP_INV;
	assign sing3     = det_s3 == '0;
	assign needs_out = !inv3 || sing3;
	assign s3_go     = v_s3 && !div_busy && (!needs_out || out_can);
	assign en3       = !v_s3 || s3_go;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign pop       = en1 && head_valid;
	assign div_take  = div_done && out_can;

	// multiplier operand select
	always_comb begin
		if (op_s1 == OP_INV) begin
			ma0 = 33'(mat.d); mb0 = dx_s1;
			ma1 = 33'(mat.c); mb1 = dy_s1;
			ma2 = 33'(mat.a); mb2 = dy_s1;
			ma3 = 33'(mat.b); mb3 = dx_s1;
		end else begin
			ma0 = 33'(mat.a); mb0 = px_s1;
			ma1 = 33'(mat.c); mb1 = py_s1;
			ma2 = 33'(mat.b); mb2 = px_s1;
			ma3 = 33'(mat.d); mb3 = py_s1;
		end
		pr0  = ma0 * mb0;
		pr1  = ma1 * mb1;
		pr2  = ma2 * mb2;
		pr3  = ma3 * mb3;
		prad = mat.a * mat.d;
		prbc = mat.b * mat.c;
	end

	// sums; the determinant is formed at the stage-3 register
	always_comb begin
		txs = {{(SUM_W-COORD_W){mat.tx[COORD_W-1]}}, mat.tx} <<< FRAC_BITS;
		tys = {{(SUM_W-COORD_W){mat.ty[COORD_W-1]}}, mat.ty} <<< FRAC_BITS;
		if (op_s2 == OP_INV) begin
			sumx = p0_s2 - p1_s2;
			sumy = p2_s2 - p3_s2;
		end else begin
			sumx = p0_s2 + p1_s2 + txs;
			sumy = p2_s2 + p3_s2 + tys;
		end
	end

	// forward rounding and saturation, inverse divider request
	always_comb begin
		magx   = sx_s3[SUM_W-1] ? SUM_W'(-sx_s3) : SUM_W'(sx_s3);
		magy   = sy_s3[SUM_W-1] ? SUM_W'(-sy_s3) : SUM_W'(sy_s3);
		half   = (SUM_W+1)'(1) << (FRAC_BITS - 1);
		rx_rnd = ({1'b0, magx} + half) >> FRAC_BITS;
		ry_rnd = ({1'b0, magy} + half) >> FRAC_BITS;
		fx     = atx_saturate(sx_s3[SUM_W-1], MAG_W'(rx_rnd));
		fy     = atx_saturate(sy_s3[SUM_W-1], MAG_W'(ry_rnd));
		if (inv3) begin
			s3_res = '{rx: '0, ry: '0, sing: 1'b1, ovf: 1'b0};
		end else begin
			s3_res = '{rx: fx.val, ry: fy.val, sing: 1'b0, ovf: fx.ovf || fy.ovf};
		end
		dreq.negx = sx_s3[SUM_W-1] != det_s3[DET_W-1];
		dreq.negy = sy_s3[SUM_W-1] != det_s3[DET_W-1];
		dreq.magx = magx;
		dreq.magy = magy;
		dreq.dv   = det_s3[DET_W-1] ? DET_W'(-det_s3) : DET_W'(det_s3);
	end

	atx_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (s3_go && !needs_out),
		.req   (dreq),
		.take  (div_take),
		.busy  (div_busy),
		.done  (div_done),
		.res   (div_res)
	);

	// pipeline payload
	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1 <= head.op;
			px_s1 <= 33'(head.px);
			py_s1 <= 33'(head.py);
			dx_s1 <= 33'(head.px) - 33'(mat.tx);
			dy_s1 <= 33'(head.py) - 33'(mat.ty);
		end
		if (en2) begin
			op_s2 <= op_s1;
			p0_s2 <= pr0;
			p1_s2 <= pr1;
			p2_s2 <= pr2;
			p3_s2 <= pr3;
			ad_s2 <= prad;
			bc_s2 <= prbc;
		end
		if (en3) begin
			op_s3  <= op_s2;
			sx_s3  <= sumx;
			sy_s3  <= sumy;
			det_s3 <= DET_W'(ad_s2) - DET_W'(bc_s2);
		end
		if (s3_go && needs_out) begin
			out_q <= s3_res;
		end else if (div_take) begin
			out_q <= div_res;
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1) v_s1 <= head_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if ((s3_go && needs_out) || div_take) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_v_q;
	assign res           = out_q;
	assign stat.div_busy = div_busy;
	assign stat.s3_issue = s3_go;

endmodule

// ===== hdl/affine_2d_point_transform.sv =====
// Forward points: queue, operand, product and sum stages, output register; one point
// per cycle while the output is ready and the divider is idle. Inverse Q16.16 points
// also use the bit-serial divider, one inverse at a time; later points wait in order.
// Four-entry input queue and a registered output decouple the two sides.
// Reset loads the identity matrix and empties the queue, pipeline and divider.
module affine_2d_point_transform #(
	parameter int FRAC_BITS = atx_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [atx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic [31:0]                   point_x,
	input  logic [31:0]                   point_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [31:0]                   result_x,
	output logic [31:0]                   result_y,
	output logic                          singular,
	output logic                          overflow
);
	import atx_pkg::*;

	atx_mat_t  mat_q;
	atx_item_t head;
	logic      head_valid;
	logic      pop;
	atx_res_t  res;
	atx_stat_t stat;

	assign cfg_ready = 1'b1;

	// matrix registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q.a  <= 32'(1) << FRAC_BITS;
			mat_q.c  <= '0;
			mat_q.tx <= '0;
			mat_q.b  <= '0;
			mat_q.d  <= 32'(1) << FRAC_BITS;
			mat_q.ty <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SCALE_X:  mat_q.a  <= cfg_data;
				REG_SHEAR_X:  mat_q.c  <= cfg_data;
				REG_OFFSET_X: mat_q.tx <= cfg_data;
				REG_SHEAR_Y:  mat_q.b  <= cfg_data;
				REG_SCALE_Y:  mat_q.d  <= cfg_data;
				REG_OFFSET_Y: mat_q.ty <= cfg_data;
				default: ;
			endcase
		end
	end

	atx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.point_x   (point_x),
		.point_y   (point_y),
		.pop       (pop),
		.head      (head),
		.head_valid(head_valid)
	);

	atx_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mat       (mat_q),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res),
		.stat      (stat)
	);

	assign result_x = res.rx;
	assign result_y = res.ry;
	assign singular = res.sing;
	assign overflow = res.ovf;

`ifndef SYNTHESIS
	// a singular result carries zero coordinates and no overflow
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> result_x == '0 && result_y == '0 && !overflow)
		else $error("singular result with nonzero payload");

	// stage three never issues while the divider holds an item
	a_div_order: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_busy |-> !stat.s3_issue)
		else $error("issue past a busy divider");

	// an accepted beat leaves the queue nonempty
	a_queue_push: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> head_valid)
		else $error("queue empty after push");
`endif

endmodule
